[rtl/core/gie_pkg.sv]
// Package with the shared types, constants and code tables of the gamepad event generator.
`default_nettype none
package gie_pkg;

   localparam int SCANNED_BUTTONS = 21;
   localparam int QUEUE_DEPTH     = 2;

   localparam logic [2:0] KIND_DOWN     = 3'd0;
   localparam logic [2:0] KIND_UP       = 3'd1;
   localparam logic [2:0] KIND_REPEATED = 3'd2;
   localparam logic [2:0] KIND_TRIGGER  = 3'd3;
   localparam logic [2:0] KIND_STICK    = 3'd4;

   localparam logic [4:0] CODE_NONE   = 5'd31;
   localparam logic [4:0] CODE_LTRIG  = 5'd23;
   localparam logic [4:0] CODE_RTRIG  = 5'd22;
   localparam logic [4:0] CODE_LSTICK = 5'd6;
   localparam logic [4:0] CODE_RSTICK = 5'd7;

   localparam logic [2:0] CSR_TRIG_DOWN   = 3'd0;
   localparam logic [2:0] CSR_TRIG_DELTA  = 3'd1;
   localparam logic [2:0] CSR_STICK_DOWN  = 3'd2;
   localparam logic [2:0] CSR_STICK_DELTA = 3'd3;
   localparam logic [2:0] CSR_RPT_FIRST   = 3'd4;
   localparam logic [2:0] CSR_RPT_PERIOD  = 3'd5;

   localparam logic [7:0]  TRIG_RELEASE = 8'd13;
   localparam logic [32:0] STICK_REL2   = 33'd24157225;
   localparam logic [19:0] TIMER_MAX    = 20'hFFFFF;

   localparam logic [1:0] DIR_UP    = 2'd0;
   localparam logic [1:0] DIR_DOWN  = 2'd1;
   localparam logic [1:0] DIR_RIGHT = 2'd2;
   localparam logic [1:0] DIR_LEFT  = 2'd3;

   typedef struct packed {
      logic [20:0]        buttons;
      logic [7:0]         ltrig;
      logic [7:0]         rtrig;
      logic signed [15:0] lx;
      logic signed [15:0] ly;
      logic signed [15:0] rx;
      logic signed [15:0] ry;
      logic [15:0]        elapsed;
   } snap_type;

   typedef struct packed {
      logic [2:0]         kind;
      logic [4:0]         code;
      logic [7:0]         trig;
      logic signed [15:0] sx;
      logic signed [15:0] sy;
   } event_type;

   typedef struct packed {
      logic [7:0]  trig_down;
      logic [7:0]  trig_delta;
      logic [14:0] stick_down;
      logic [14:0] stick_delta;
      logic [15:0] rpt_first;
      logic [15:0] rpt_period;
   } cfg_type;

   typedef struct packed {
      logic busy;
      logic pend_valid;
   } back_status_type;

   typedef enum logic [2:0] {
      PH_BTN, PH_TRIG, PH_STK_MUL, PH_STK_SUM, PH_STK, PH_RPT, PH_FIN
   } phase_type;

   typedef enum logic [1:0] {
      SB_DECIDE, SB_DOWN, SB_REPEAT, SB_MOVE
   } sub_type;

   function automatic logic [4:0] dir_code(input logic right, input logic [1:0] dir);
      logic [4:0] code;
      code = 5'd21;
      if (right) begin
         code = 5'd24 + {3'd0, dir};
      end else begin
         unique case (dir)
            DIR_UP:    code = 5'd28;
            DIR_DOWN:  code = 5'd29;
            DIR_RIGHT: code = 5'd30;
            DIR_LEFT:  code = 5'd21;
            default:   code = 5'd21;
         endcase
      end
      return code;
   endfunction

endpackage
`default_nettype wire

[rtl/core/gie_front.sv]
// Front end: takes requests, unpacks them and drops snapshots from a disconnected pad.
`default_nettype none
module gie_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [119:0]      req_tdata,
   input  wire logic              q_full,
   output logic                   q_push,
   output gie_pkg::snap_type      q_data
);
   import gie_pkg::*;

   logic connected;

   assign connected  = req_tdata[117];
   assign req_tready = !q_full;
   assign q_push     = req_tvalid && req_tready && connected;

   assign q_data.buttons = req_tdata[20:0];
   assign q_data.ltrig   = req_tdata[28:21];
   assign q_data.rtrig   = req_tdata[36:29];
   assign q_data.lx      = req_tdata[52:37];
   assign q_data.ly      = req_tdata[68:53];
   assign q_data.rx      = req_tdata[84:69];
   assign q_data.ry      = req_tdata[100:85];
   assign q_data.elapsed = req_tdata[116:101];
endmodule
`default_nettype wire

[rtl/core/gie_queue.sv]
// Short queue of snapshots between the front end and the event sequencer.
`default_nettype none
module gie_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire gie_pkg::snap_type push_data,
   input  wire logic              pop,
   output logic                   full,
   output logic                   not_empty,
   output gie_pkg::snap_type      pop_data
);
   import gie_pkg::*;

   snap_type   entry_ff [QUEUE_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full      = (count_ff == 2'(QUEUE_DEPTH));
   assign not_empty = (count_ff != 2'd0);
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule
`default_nettype wire

[rtl/core/gie_back.sv]
// Back end: walks one snapshot at a time through buttons, triggers, sticks and auto-repeat.
`default_nettype none
module gie_back (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire gie_pkg::cfg_type         cfg,
   input  wire logic                     q_not_empty,
   input  wire gie_pkg::snap_type        q_data,
   output logic                          q_pop,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output gie_pkg::event_type            rsp_event,
   output logic                          rsp_last,
   output gie_pkg::back_status_type      status
);
   import gie_pkg::*;

   phase_type          phase_ff, phase_in;
   sub_type            sub_ff, sub_in;
   logic               busy_ff, busy_in;
   logic [4:0]         idx_ff, idx_in;
   logic [2:0]         mcnt_ff, mcnt_in;
   snap_type           snap_ff, snap_in;

   logic [20:0]        prior_ff, prior_in;
   logic [1:0]         trig_held_ff, trig_held_in;
   logic [1:0]         stick_held_ff, stick_held_in;
   logic [1:0]         sector_ff [2];
   logic [1:0]         sector_in [2];
   logic [7:0]         trig_snap_ff [2];
   logic [7:0]         trig_snap_in [2];
   logic signed [15:0] stick_snap_ff [4];
   logic signed [15:0] stick_snap_in [4];
   logic [4:0]         held_button_ff, held_button_in;
   logic [19:0]        timer_ff, timer_in;
   logic [4:0]         rpt_code_ff, rpt_code_in;

   logic [31:0]        prod_ff [8];
   logic [32:0]        len2_ff, len2_in;
   logic [32:0]        d2_ff, d2_in;
   logic [32:0]        pp2_ff, pp2_in;
   logic [31:0]        down2_ff, down2_in;
   logic [31:0]        delta2_ff, delta2_in;
   logic [16:0]        fp_ff;
   logic [17:0]        fpp_ff;

   event_type          pend_ff, pend_in;
   logic               pend_valid_ff, pend_valid_in;
   event_type          out_ff, out_in;
   logic               out_last_ff, out_last_in;
   logic               out_valid_ff, out_valid_in;

   logic               out_free, adv, run, out_load;
   logic               gen_valid;
   event_type          gen_ev;
   logic               btn_next;

   logic               t;
   logic [7:0]         tcur, tprev, tdiff;
   logic               tmoved;
   logic [4:0]         tcode;
   logic               side;
   logic signed [15:0] sx, sy, px, py;
   logic signed [16:0] dx, dy, negx, y17, mop;
   logic signed [33:0] mprod;
   logic [1:0]         cdir, ssec;
   logic               sheld, curdown, smoved;
   logic [20:0]        tsum;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign adv       = !pend_valid_ff || out_free;
   assign run       = busy_ff && adv;
   assign out_load  = run && pend_valid_ff && (gen_valid || (phase_ff == PH_FIN));
   assign q_pop     = !busy_ff && q_not_empty;

   assign rsp_valid = out_valid_ff;
   assign rsp_event = out_ff;
   assign rsp_last  = out_last_ff;
   assign status    = '{busy: busy_ff, pend_valid: pend_valid_ff};

   always_comb begin
      t      = idx_ff[0];
      tcur   = t ? snap_ff.rtrig : snap_ff.ltrig;
      tprev  = trig_snap_ff[t];
      tdiff  = (tprev > tcur) ? (tprev - tcur) : (tcur - tprev);
      tmoved = (tcur > cfg.trig_delta) ? (tdiff >= cfg.trig_delta) : (tprev > cfg.trig_delta);
      tcode  = t ? CODE_RTRIG : CODE_LTRIG;

      side   = idx_ff[0];
      sx     = side ? snap_ff.rx : snap_ff.lx;
      sy     = side ? snap_ff.ry : snap_ff.ly;
      px     = side ? stick_snap_ff[2] : stick_snap_ff[0];
      py     = side ? stick_snap_ff[3] : stick_snap_ff[1];
      dx     = {sx[15], sx} - {px[15], px};
      dy     = {sy[15], sy} - {py[15], py};
      negx   = -{sx[15], sx};
      y17    = {sy[15], sy};
      if (sy > sx) begin
         cdir = (y17 > negx) ? DIR_UP : DIR_LEFT;
      end else begin
         cdir = (y17 < negx) ? DIR_DOWN : DIR_RIGHT;
      end
      sheld   = stick_held_ff[side];
      ssec    = sector_ff[side];
      curdown = len2_ff > {1'b0, down2_ff};
      smoved  = (len2_ff > {1'b0, delta2_ff}) ? (d2_ff >= {1'b0, delta2_ff})
                                              : (pp2_ff > {1'b0, delta2_ff});

      unique case (mcnt_ff)
         3'd0:    mop = {sx[15], sx};
         3'd1:    mop = {sy[15], sy};
         3'd2:    mop = dx;
         3'd3:    mop = dy;
         3'd4:    mop = {px[15], px};
         3'd5:    mop = {py[15], py};
         3'd6:    mop = {2'b00, cfg.stick_down};
         3'd7:    mop = {2'b00, cfg.stick_delta};
         default: mop = '0;
      endcase
      mprod = mop * mop;
      tsum  = {1'b0, timer_ff} + {5'd0, snap_ff.elapsed};
   end

   always_comb begin
      phase_in       = phase_ff;
      sub_in         = sub_ff;
      busy_in        = busy_ff;
      idx_in         = idx_ff;
      mcnt_in        = mcnt_ff;
      snap_in        = snap_ff;
      prior_in       = prior_ff;
      trig_held_in   = trig_held_ff;
      stick_held_in  = stick_held_ff;
      sector_in      = sector_ff;
      trig_snap_in   = trig_snap_ff;
      stick_snap_in  = stick_snap_ff;
      held_button_in = held_button_ff;
      timer_in       = timer_ff;
      rpt_code_in    = rpt_code_ff;
      len2_in        = len2_ff;
      d2_in          = d2_ff;
      pp2_in         = pp2_ff;
      down2_in       = down2_ff;
      delta2_in      = delta2_ff;
      gen_valid      = 1'b0;
      gen_ev         = '0;
      btn_next       = 1'b0;

      if (q_pop) begin
         snap_in  = q_data;
         busy_in  = 1'b1;
         phase_in = PH_BTN;
         sub_in   = SB_DECIDE;
         idx_in   = 5'd0;
      end else if (run) begin
         unique case (phase_ff)
            PH_BTN: begin
               if (sub_ff == SB_REPEAT) begin
                  gen_valid = 1'b1;
                  gen_ev    = '{KIND_REPEATED, rpt_code_ff, 8'd0, 16'sd0, 16'sd0};
                  btn_next  = 1'b1;
               end else if (snap_ff.buttons[idx_ff] && !prior_ff[idx_ff]) begin
                  gen_valid      = 1'b1;
                  gen_ev         = '{KIND_DOWN, idx_ff, 8'd0, 16'sd0, 16'sd0};
                  held_button_in = idx_ff;
                  timer_in       = '0;
                  rpt_code_in    = idx_ff;
                  sub_in         = SB_REPEAT;
               end else begin
                  if (!snap_ff.buttons[idx_ff] && prior_ff[idx_ff]) begin
                     gen_valid      = 1'b1;
                     gen_ev         = '{KIND_UP, idx_ff, 8'd0, 16'sd0, 16'sd0};
                     held_button_in = CODE_NONE;
                  end
                  btn_next = 1'b1;
               end
            end
            PH_TRIG: begin
               unique case (sub_ff)
                  SB_DECIDE, SB_DOWN: begin
                     sub_in = SB_MOVE;
                     if (!trig_held_ff[t] && tcur > cfg.trig_down) begin
                        gen_valid       = 1'b1;
                        gen_ev          = '{KIND_DOWN, tcode, 8'd0, 16'sd0, 16'sd0};
                        trig_held_in[t] = 1'b1;
                        held_button_in  = tcode;
                        timer_in        = '0;
                        rpt_code_in     = tcode;
                        sub_in          = SB_REPEAT;
                     end else if (trig_held_ff[t] && tcur < TRIG_RELEASE) begin
                        gen_valid       = 1'b1;
                        gen_ev          = '{KIND_UP, tcode, 8'd0, 16'sd0, 16'sd0};
                        trig_held_in[t] = 1'b0;
                        held_button_in  = CODE_NONE;
                     end
                  end
                  SB_REPEAT: begin
                     gen_valid = 1'b1;
                     gen_ev    = '{KIND_REPEATED, rpt_code_ff, 8'd0, 16'sd0, 16'sd0};
                     sub_in    = SB_MOVE;
                  end
                  SB_MOVE: begin
                     if (tmoved) begin
                        gen_valid       = 1'b1;
                        gen_ev          = '{KIND_TRIGGER, tcode, tcur, 16'sd0, 16'sd0};
                        trig_snap_in[0] = snap_ff.ltrig;
                        trig_snap_in[1] = snap_ff.rtrig;
                     end
                     sub_in = SB_DECIDE;
                     idx_in = 5'd1;
                     if (t) begin
                        phase_in = PH_STK_MUL;
                        mcnt_in  = 3'd0;
                     end
                  end
                  default: sub_in = SB_DECIDE;
               endcase
            end
            PH_STK_MUL: begin
               mcnt_in = mcnt_ff + 3'd1;
               if (mcnt_ff == 3'd7) begin
                  phase_in = PH_STK_SUM;
               end
            end
            PH_STK_SUM: begin
               len2_in   = {1'b0, prod_ff[0]} + {1'b0, prod_ff[1]};
               d2_in     = {1'b0, prod_ff[2]} + {1'b0, prod_ff[3]};
               pp2_in    = {1'b0, prod_ff[4]} + {1'b0, prod_ff[5]};
               down2_in  = prod_ff[6];
               delta2_in = prod_ff[7];
               phase_in  = PH_STK;
               sub_in    = SB_DECIDE;
            end
            PH_STK: begin
               unique case (sub_ff)
                  SB_DECIDE: begin
                     sub_in = SB_MOVE;
                     if (!sheld && curdown) begin
                        sector_in[side]     = cdir;
                        stick_held_in[side] = 1'b1;
                        gen_valid           = 1'b1;
                        gen_ev = '{KIND_DOWN, dir_code(side, cdir), 8'd0, 16'sd0, 16'sd0};
                        held_button_in      = dir_code(side, cdir);
                        timer_in            = '0;
                        rpt_code_in         = dir_code(side, cdir);
                        sub_in              = SB_REPEAT;
                     end else if (sheld && len2_ff < STICK_REL2) begin
                        gen_valid           = 1'b1;
                        gen_ev = '{KIND_UP, dir_code(side, ssec), 8'd0, 16'sd0, 16'sd0};
                        stick_held_in[side] = 1'b0;
                        held_button_in      = CODE_NONE;
                     end else if (sheld && curdown && cdir != ssec) begin
                        gen_valid       = 1'b1;
                        gen_ev = '{KIND_UP, dir_code(side, ssec), 8'd0, 16'sd0, 16'sd0};
                        held_button_in  = CODE_NONE;
                        sector_in[side] = cdir;
                        sub_in          = SB_DOWN;
                     end
                  end
                  SB_DOWN: begin
                     gen_valid      = 1'b1;
                     gen_ev = '{KIND_DOWN, dir_code(side, ssec), 8'd0, 16'sd0, 16'sd0};
                     held_button_in = dir_code(side, ssec);
                     timer_in       = '0;
                     rpt_code_in    = dir_code(side, ssec);
                     sub_in         = SB_REPEAT;
                  end
                  SB_REPEAT: begin
                     gen_valid = 1'b1;
                     gen_ev    = '{KIND_REPEATED, rpt_code_ff, 8'd0, 16'sd0, 16'sd0};
                     sub_in    = SB_MOVE;
                  end
                  SB_MOVE: begin
                     if (smoved) begin
                        gen_valid = 1'b1;
                        gen_ev = '{KIND_STICK, side ? CODE_RSTICK : CODE_LSTICK, 8'd0, sx, sy};
                        stick_snap_in[0] = snap_ff.lx;
                        stick_snap_in[1] = snap_ff.ly;
                        stick_snap_in[2] = snap_ff.rx;
                        stick_snap_in[3] = snap_ff.ry;
                     end
                     sub_in = SB_DECIDE;
                     if (side) begin
                        idx_in   = 5'd0;
                        mcnt_in  = 3'd0;
                        phase_in = PH_STK_MUL;
                     end else begin
                        phase_in = PH_RPT;
                     end
                  end
                  default: sub_in = SB_DECIDE;
               endcase
            end
            PH_RPT: begin
               if (sub_ff == SB_DECIDE) begin
                  timer_in = tsum[20] ? TIMER_MAX : tsum[19:0];
                  sub_in   = SB_MOVE;
               end else begin
                  if (timer_ff >= {4'd0, cfg.rpt_first} && held_button_ff != CODE_NONE &&
                      (timer_ff < {3'd0, fp_ff} || timer_ff > {2'd0, fpp_ff})) begin
                     gen_valid = 1'b1;
                     gen_ev    = '{KIND_REPEATED, held_button_ff, 8'd0, 16'sd0, 16'sd0};
                     timer_in  = {3'd0, fp_ff};
                  end
                  phase_in = PH_FIN;
               end
            end
            PH_FIN: begin
               busy_in = 1'b0;
            end
            default: phase_in = PH_FIN;
         endcase

         if (btn_next) begin
            sub_in = SB_DECIDE;
            if (idx_ff == 5'(SCANNED_BUTTONS - 1)) begin
               prior_in = snap_ff.buttons;
               phase_in = PH_TRIG;
               idx_in   = 5'd0;
            end else begin
               idx_in = idx_ff + 5'd1;
            end
         end
      end
   end

   always_comb begin
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      if (run && gen_valid) begin
         pend_in       = gen_ev;
         pend_valid_in = 1'b1;
      end else if (run && phase_ff == PH_FIN) begin
         pend_valid_in = 1'b0;
      end
      out_in       = out_load ? pend_ff : out_ff;
      out_last_in  = out_load ? (phase_ff == PH_FIN) : out_last_ff;
      out_valid_in = out_load ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_FIN;
         sub_ff         <= SB_DECIDE;
         busy_ff        <= 1'b0;
         pend_valid_ff  <= 1'b0;
         out_valid_ff   <= 1'b0;
         prior_ff       <= '0;
         trig_held_ff   <= '0;
         stick_held_ff  <= '0;
         sector_ff      <= '{default: 2'd0};
         trig_snap_ff   <= '{default: 8'd0};
         stick_snap_ff  <= '{default: 16'sd0};
         held_button_ff <= CODE_NONE;
         timer_ff       <= '0;
      end else begin
         phase_ff       <= phase_in;
         sub_ff         <= sub_in;
         busy_ff        <= busy_in;
         pend_valid_ff  <= pend_valid_in;
         out_valid_ff   <= out_valid_in;
         prior_ff       <= prior_in;
         trig_held_ff   <= trig_held_in;
         stick_held_ff  <= stick_held_in;
         sector_ff      <= sector_in;
         trig_snap_ff   <= trig_snap_in;
         stick_snap_ff  <= stick_snap_in;
         held_button_ff <= held_button_in;
         timer_ff       <= timer_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      mcnt_ff     <= mcnt_in;
      snap_ff     <= snap_in;
      rpt_code_ff <= rpt_code_in;
      len2_ff     <= len2_in;
      d2_ff       <= d2_in;
      pp2_ff      <= pp2_in;
      down2_ff    <= down2_in;
      delta2_ff   <= delta2_in;
      pend_ff     <= pend_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
      fp_ff       <= {1'b0, cfg.rpt_first} + {1'b0, cfg.rpt_period};
      fpp_ff      <= {1'b0, fp_ff} + {2'b00, cfg.rpt_period};
      if (run && phase_ff == PH_STK_MUL) begin
         prod_ff[mcnt_ff] <= mprod[31:0];
      end
   end
endmodule
`default_nettype wire

[rtl/core/gamepad_input_event_generator_core.sv]
// Top level of the gamepad event generator: register file, front end, queue and sequencer.
// A request waits in the queue until the sequencer is free. Each event is held pending
// until the sequencer forms the next one, then goes to the output register; the last one
// goes at the closing step. Per snapshot: a fetch step, 21 button, 4 trigger and 2 x 11
// stick steps (eight shared-multiplier squarings each), 3 closing steps, one per repeat
// after a down and per direction change. Reset: synchronous, spares the data registers.
`default_nettype none
module gamepad_input_event_generator_core (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // button_bits[20:0], left_trigger[28:21], right_trigger[36:29], left_x[52:37],
   // left_y[68:53], right_x[84:69], right_y[100:85], elapsed_ms[116:101], connected[117]
   input  wire logic [119:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // button_code[4:0], trigger_value[12:5], stick_x[28:13], stick_y[44:29]
   output logic [47:0]       rsp_tdata,
   // event_kind[2:0]
   output logic [2:0]        rsp_tuser,
   output logic              rsp_tlast,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [2:0]   csr_index,
   input  wire logic [15:0]  csr_data
);
   import gie_pkg::*;

   cfg_type         cfg_ff, cfg_in;
   logic            q_full, q_push, q_pop, q_not_empty;
   snap_type        q_in_data, q_out_data;
   event_type       rsp_event;
   back_status_type status;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_TRIG_DOWN:   cfg_in.trig_down   = csr_data[7:0];
            CSR_TRIG_DELTA:  cfg_in.trig_delta  = csr_data[7:0];
            CSR_STICK_DOWN:  cfg_in.stick_down  = csr_data[14:0];
            CSR_STICK_DELTA: cfg_in.stick_delta = csr_data[14:0];
            CSR_RPT_FIRST:   cfg_in.rpt_first   = csr_data;
            CSR_RPT_PERIOD:  cfg_in.rpt_period  = csr_data;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{trig_down: 8'd128, trig_delta: 8'd38, stick_down: 15'd16384,
                     stick_delta: 15'd4915, rpt_first: 16'd500, rpt_period: 16'd50};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   gie_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_data     (q_in_data)
   );

   gie_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in_data),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .pop_data  (q_out_data)
   );

   gie_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .q_not_empty (q_not_empty),
      .q_data      (q_out_data),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_event   (rsp_event),
      .rsp_last    (rsp_tlast),
      .status      (status)
   );

   assign rsp_tdata = {3'd0, rsp_event.sy, rsp_event.sx, rsp_event.trig, rsp_event.code};
   assign rsp_tuser = rsp_event.kind;

   assert property (@(posedge clock) disable iff (reset) !status.busy |-> !status.pend_valid)
      else $error("event left pending after the sequencer went idle");
   assert property (@(posedge clock) disable iff (reset) q_pop |-> !status.busy)
      else $error("snapshot taken while another is in progress");
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_TRIGGER |-> rsp_tdata[4:0] == CODE_LTRIG ||
                                                  rsp_tdata[4:0] == CODE_RTRIG)
      else $error("trigger event carries a foreign code");
endmodule
`default_nettype wire
